>>> rtl/core/crc_framed_packet_parser_top_macros.svh
// Assertion macros for the frame parser checker.
`ifndef CRC_FRAMED_PACKET_PARSER_TOP_MACROS_SVH
`define CRC_FRAMED_PACKET_PARSER_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define CFPP_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define CFPP_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/cfpp_pkg.sv
// ----------------------------------------------------------------------------
// cfpp_pkg
// Types and constants of the framed packet parser.
// ----------------------------------------------------------------------------
package cfpp_pkg;

  localparam int BUFFER_DEPTH = 128;
  localparam int ADDR_W       = 7;
  localparam int CNT_W        = 8;
  localparam int MAX_PAYLOAD  = 48;
  localparam int LEN_W        = 6;
  localparam int OFF_W        = 6;

  localparam logic [CNT_W-1:0] HEADER_BYTES = 8'd6;
  localparam logic [CNT_W-1:0] FRAME_OVERHEAD = 8'd8;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam logic [2:0] ST_NONE    = 3'd0;
  localparam logic [2:0] ST_FRAME   = 3'd1;
  localparam logic [2:0] ST_VERSION = 3'd2;
  localparam logic [2:0] ST_LENGTH  = 3'd3;
  localparam logic [2:0] ST_CRC     = 3'd4;

  localparam logic [1:0] REG_SOF1    = 2'd0;
  localparam logic [1:0] REG_SOF2    = 2'd1;
  localparam logic [1:0] REG_VERSION = 2'd2;
  localparam logic [1:0] REG_TIMEOUT = 2'd3;

  typedef struct packed {
    logic       init;
    logic       start;
    logic [7:0] data;
  } crc_ctrl_t;

endpackage

>>> rtl/core/cfpp_channels.sv
// ----------------------------------------------------------------------------
// cfpp channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface cfpp_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [7:0]  data_byte;
  logic [31:0] now_ms;

  modport source (output valid, mode, data_byte, now_ms, input ready);
  modport sink   (input valid, mode, data_byte, now_ms, output ready);
endinterface

interface cfpp_out_if;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   status;
  logic [7:0]                   frame_id;
  logic [7:0]                   sequence_number;
  logic [cfpp_pkg::LEN_W-1:0]   frame_len;
  logic [7:0]                   payload_byte;
  logic                         last;

  modport source (output valid, status, frame_id, sequence_number, frame_len,
                  payload_byte, last, input ready);
  modport sink   (input valid, status, frame_id, sequence_number, frame_len,
                  payload_byte, last, output ready);
endinterface

>>> rtl/core/crc_framed_packet_parser_top.sv
// ----------------------------------------------------------------------------
// crc_framed_packet_parser_top
// Ring-buffered SOF/length/CRC-16 frame parser with timeout on partial frames.
// ----------------------------------------------------------------------------
// Checking: a rescan repeats the frame check per dropped byte, and each CRC byte
//   goes through the bit-serial CRC unit; each read waits on the registered port.
// Throughput: one item at a time; a new item is taken after the last result of the
//   previous one is accepted.
// Reset: synchronous; empties the buffer, clears the timer, loads register defaults.
module crc_framed_packet_parser_top (
  input  logic              clk,
  input  logic              rst,
  cfpp_in_if.sink           pkt_in,
  cfpp_out_if.source        pkt_out,
  input  logic              cfg_write_en,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_TMO  = 5'd1;
  localparam logic [4:0] S_SCAN = 5'd2;
  localparam logic [4:0] S_RDW  = 5'd3;
  localparam logic [4:0] S_P0   = 5'd4;
  localparam logic [4:0] S_P1   = 5'd5;
  localparam logic [4:0] S_VER  = 5'd6;
  localparam logic [4:0] S_LEN  = 5'd7;
  localparam logic [4:0] S_CRCB = 5'd8;
  localparam logic [4:0] S_CRCW = 5'd9;
  localparam logic [4:0] S_RX0  = 5'd10;
  localparam logic [4:0] S_RX1  = 5'd11;
  localparam logic [4:0] S_ID   = 5'd12;
  localparam logic [4:0] S_SEQ  = 5'd13;
  localparam logic [4:0] S_PL   = 5'd14;
  localparam logic [4:0] S_OUT  = 5'd15;

  localparam int AW = cfpp_pkg::ADDR_W;
  localparam int CW = cfpp_pkg::CNT_W;
  localparam int OW = cfpp_pkg::OFF_W;
  localparam int LW = cfpp_pkg::LEN_W;

  logic [4:0]    state;
  logic [4:0]    ret_st;
  logic [OW-1:0] rd_off;
  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic          active;
  logic [31:0]   started;
  logic [7:0]    sof1;
  logic [7:0]    sof2;
  logic [7:0]    version;
  logic [15:0]   timeout;
  logic [31:0]   now_r;
  logic [2:0]    last_err;
  logic [LW-1:0] len;
  logic [OW-1:0] crc_off;
  logic [7:0]    rx_lo;
  logic [7:0]    msg_id;
  logic [7:0]    seq_no;
  logic [LW-1:0] k;
  logic          is_frame;

  logic          out_valid;
  logic [2:0]    out_status;
  logic [7:0]    out_id;
  logic [7:0]    out_seq;
  logic [LW-1:0] out_len;
  logic [7:0]    out_byte;
  logic          out_last;

  logic [7:0]    mem [cfpp_pkg::BUFFER_DEPTH];
  logic [7:0]    rdata;
  logic [AW-1:0] wr_addr;
  logic          in_acc;
  logic          full;
  logic          len_ok;
  logic          len_avail;
  logic [CW-1:0] flen;
  logic [31:0]   elapsed;

  cfpp_pkg::crc_ctrl_t crc_ctrl;
  logic [15:0]         crc;
  logic                crc_busy;

  cfpp_crc u_crc (
    .clk  (clk),
    .rst  (rst),
    .ctrl (crc_ctrl),
    .crc  (crc),
    .busy (crc_busy)
  );

  assign in_acc  = pkt_in.valid && pkt_in.ready;
  assign full    = (count == CW'(cfpp_pkg::BUFFER_DEPTH));
  assign wr_addr = full ? head : head + count[AW-1:0];
  assign flen    = cfpp_pkg::FRAME_OVERHEAD + CW'(len);
  assign elapsed = now_r - started;

  always_comb begin
    len_ok    = (rdata <= 8'(cfpp_pkg::MAX_PAYLOAD));
    len_avail = (count >= cfpp_pkg::FRAME_OVERHEAD + rdata);
    crc_ctrl.init  = (state == S_LEN) && len_ok && len_avail;
    crc_ctrl.start = (state == S_CRCB);
    crc_ctrl.data  = rdata;
  end

  // Ring store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (in_acc && !pkt_in.mode) begin
      mem[wr_addr] <= pkt_in.data_byte;
    end
    rdata <= mem[head + AW'(rd_off)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sof1    <= 8'hAA;
      sof2    <= 8'h55;
      version <= 8'h01;
      timeout <= 16'd100;
    end else if (cfg_write_en) begin
      case (cfg_index)
        cfpp_pkg::REG_SOF1:    sof1    <= cfg_data[7:0];
        cfpp_pkg::REG_SOF2:    sof2    <= cfg_data[7:0];
        cfpp_pkg::REG_VERSION: version <= cfg_data[7:0];
        cfpp_pkg::REG_TIMEOUT: timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      active    <= 1'b0;
      started   <= '0;
      out_valid <= 1'b0;
      rd_off    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            now_r    <= pkt_in.now_ms;
            last_err <= cfpp_pkg::ST_NONE;
            if (!pkt_in.mode) begin
              if (full) begin
                head <= head + AW'(1);
              end else begin
                count <= count + CW'(1);
              end
            end
            state <= S_TMO;
          end
        end
        S_TMO: begin
          if (active && (elapsed >= {16'h0000, timeout})) begin
            active <= 1'b0;
            if (count != '0) begin
              head  <= head + AW'(1);
              count <= count - CW'(1);
            end
          end
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (count == '0) begin
            active     <= 1'b0;
            out_status <= last_err;
            out_id     <= '0;
            out_seq    <= '0;
            out_len    <= '0;
            out_byte   <= '0;
            out_last   <= 1'b1;
            is_frame   <= 1'b0;
            out_valid  <= 1'b1;
            state      <= S_OUT;
          end else begin
            rd_off <= OW'(0);
            ret_st <= S_P0;
            state  <= S_RDW;
          end
        end
        S_RDW: begin
          state <= ret_st;
        end
        S_P0: begin
          if (rdata != sof1) begin
            head   <= head + AW'(1);
            count  <= count - CW'(1);
            active <= 1'b0;
            state  <= S_SCAN;
          end else if (count == CW'(1)) begin
            if (!active) begin
              started <= now_r;
              active  <= 1'b1;
            end
            out_status <= last_err;
            out_id     <= '0;
            out_seq    <= '0;
            out_len    <= '0;
            out_byte   <= '0;
            out_last   <= 1'b1;
            is_frame   <= 1'b0;
            out_valid  <= 1'b1;
            state      <= S_OUT;
          end else begin
            rd_off <= OW'(1);
            ret_st <= S_P1;
            state  <= S_RDW;
          end
        end
        S_P1: begin
          if (rdata != sof2) begin
            head   <= head + AW'(1);
            count  <= count - CW'(1);
            active <= 1'b0;
            state  <= S_SCAN;
          end else if (count < cfpp_pkg::HEADER_BYTES) begin
            if (!active) begin
              started <= now_r;
              active  <= 1'b1;
            end
            out_status <= last_err;
            out_id     <= '0;
            out_seq    <= '0;
            out_len    <= '0;
            out_byte   <= '0;
            out_last   <= 1'b1;
            is_frame   <= 1'b0;
            out_valid  <= 1'b1;
            state      <= S_OUT;
          end else begin
            rd_off <= OW'(2);
            ret_st <= S_VER;
            state  <= S_RDW;
          end
        end
        S_VER: begin
          if (rdata != version) begin
            head     <= head + AW'(1);
            count    <= count - CW'(1);
            active   <= 1'b0;
            last_err <= cfpp_pkg::ST_VERSION;
            state    <= S_SCAN;
          end else begin
            rd_off <= OW'(5);
            ret_st <= S_LEN;
            state  <= S_RDW;
          end
        end
        S_LEN: begin
          if (!len_ok) begin
            head     <= head + AW'(1);
            count    <= count - CW'(1);
            active   <= 1'b0;
            last_err <= cfpp_pkg::ST_LENGTH;
            state    <= S_SCAN;
          end else if (!len_avail) begin
            if (!active) begin
              started <= now_r;
              active  <= 1'b1;
            end
            out_status <= last_err;
            out_id     <= '0;
            out_seq    <= '0;
            out_len    <= '0;
            out_byte   <= '0;
            out_last   <= 1'b1;
            is_frame   <= 1'b0;
            out_valid  <= 1'b1;
            state      <= S_OUT;
          end else begin
            len     <= rdata[LW-1:0];
            crc_off <= OW'(3);
            rd_off  <= OW'(2);
            ret_st  <= S_CRCB;
            state   <= S_RDW;
          end
        end
        S_CRCB: begin
          state <= S_CRCW;
        end
        S_CRCW: begin
          // crc covers offsets 2 .. 5+len
          if (!crc_busy) begin
            if (crc_off < OW'(6) + len) begin
              rd_off  <= crc_off;
              crc_off <= crc_off + OW'(1);
              ret_st  <= S_CRCB;
            end else begin
              rd_off <= OW'(6) + len;
              ret_st <= S_RX0;
            end
            state <= S_RDW;
          end
        end
        S_RX0: begin
          rx_lo  <= rdata;
          rd_off <= OW'(7) + len;
          ret_st <= S_RX1;
          state  <= S_RDW;
        end
        S_RX1: begin
          if ({rdata, rx_lo} != crc) begin
            head     <= head + AW'(1);
            count    <= count - CW'(1);
            active   <= 1'b0;
            last_err <= cfpp_pkg::ST_CRC;
            state    <= S_SCAN;
          end else begin
            rd_off <= OW'(3);
            ret_st <= S_ID;
            state  <= S_RDW;
          end
        end
        S_ID: begin
          msg_id <= rdata;
          rd_off <= OW'(4);
          ret_st <= S_SEQ;
          state  <= S_RDW;
        end
        S_SEQ: begin
          seq_no <= rdata;
          k      <= '0;
          if (len == '0) begin
            out_status <= cfpp_pkg::ST_FRAME;
            out_id     <= msg_id;
            out_seq    <= rdata;
            out_len    <= '0;
            out_byte   <= '0;
            out_last   <= 1'b1;
            is_frame   <= 1'b1;
            out_valid  <= 1'b1;
            state      <= S_OUT;
          end else begin
            rd_off <= OW'(6);
            ret_st <= S_PL;
            state  <= S_RDW;
          end
        end
        S_PL: begin
          out_status <= cfpp_pkg::ST_FRAME;
          out_id     <= msg_id;
          out_seq    <= seq_no;
          out_len    <= len;
          out_byte   <= rdata;
          out_last   <= (k + LW'(1) == len);
          is_frame   <= 1'b1;
          out_valid  <= 1'b1;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (pkt_out.ready) begin
            out_valid <= 1'b0;
            if (out_last) begin
              if (is_frame) begin
                head   <= head + flen[AW-1:0];
                count  <= count - flen;
                active <= 1'b0;
              end
              state <= S_IDLE;
            end else begin
              k      <= k + LW'(1);
              rd_off <= OW'(7) + OW'(k);
              ret_st <= S_PL;
              state  <= S_RDW;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign pkt_in.ready            = (state == S_IDLE);
  assign pkt_out.valid           = out_valid;
  assign pkt_out.status          = out_status;
  assign pkt_out.frame_id        = out_id;
  assign pkt_out.sequence_number = out_seq;
  assign pkt_out.frame_len       = out_len;
  assign pkt_out.payload_byte    = out_byte;
  assign pkt_out.last            = out_last;

endmodule

>>> rtl/core/cfpp_crc.sv
// ----------------------------------------------------------------------------
// cfpp_crc
// Bit-serial CRC-16/CCITT-FALSE unit.
// ----------------------------------------------------------------------------
module cfpp_crc (
  input  logic                clk,
  input  logic                rst,
  input  cfpp_pkg::crc_ctrl_t ctrl,
  output logic [15:0]         crc,
  output logic                busy
);

  logic [2:0] bit_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      bit_cnt <= '0;
    end else if (ctrl.init) begin
      crc  <= cfpp_pkg::CRC_INIT;
      busy <= 1'b0;
    end else if (ctrl.start) begin
      crc     <= crc ^ {ctrl.data, 8'h00};
      busy    <= 1'b1;
      bit_cnt <= '0;
    end else if (busy) begin
      crc     <= crc[15] ? ({crc[14:0], 1'b0} ^ cfpp_pkg::CRC_POLY) : {crc[14:0], 1'b0};
      bit_cnt <= bit_cnt + 3'd1;
      if (bit_cnt == 3'd7) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/core/cfpp_checker.sv
// ----------------------------------------------------------------------------
// cfpp_checker
// Port-level checks of the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "crc_framed_packet_parser_top_macros.svh"

module cfpp_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_status,
  input logic       out_last
);

  `CFPP_CHECK_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `CFPP_CHECK_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second transaction taken mid-item")
  `CFPP_CHECK(a_ready_clear, in_ready, !out_valid, "input ready while a result is pending")
  `CFPP_CHECK(a_err_last, out_valid && (out_status != cfpp_pkg::ST_FRAME), out_last, "non-frame result without last")

endmodule

bind crc_framed_packet_parser_top cfpp_checker u_cfpp_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (pkt_in.valid),
  .in_ready   (pkt_in.ready),
  .out_valid  (pkt_out.valid),
  .out_ready  (pkt_out.ready),
  .out_status (pkt_out.status),
  .out_last   (pkt_out.last)
);

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the framed packet parser: builds start-byte/length/
// CRC-16 frames (good, bad version, bad length, bad CRC, truncated) mixed with
// noise bytes and time polls. A scoreboard predicts every result and checks each
// output transaction in order.
// ----------------------------------------------------------------------------
module tb_top;
  import cfpp_pkg::*;

  localparam int RING_SIZE = 128;
  localparam int MAX_LEN   = 48;
  localparam int IDLE_LIMIT = 40000;

  typedef struct {
    logic [2:0] status;
    logic [7:0] msg_id;
    logic [7:0] seq_num;
    logic [5:0] pay_len;
    logic [7:0] pay_byte;
    logic       last;
  } parse_result_t;

  class frame_scoreboard;
    logic [7:0]    ring[RING_SIZE];
    logic [6:0]    head;
    int            fill;
    bit            wait_on;
    logic [31:0]   wait_t0;
    logic [7:0]    sof_a, sof_b, ver_req;
    logic [15:0]   timeout_ms;
    parse_result_t pending[$];
    int            errors;

    function void reset_state();
      head = 0; fill = 0; wait_on = 0; wait_t0 = 0;
      sof_a = 8'hAA; sof_b = 8'h55; ver_req = 8'h01; timeout_ms = 16'd100;
      errors = 0;
      foreach (ring[i]) ring[i] = 8'h00;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        REG_SOF1:    sof_a = val[7:0];
        REG_SOF2:    sof_b = val[7:0];
        REG_VERSION: ver_req = val[7:0];
        REG_TIMEOUT: timeout_ms = val;
        default: ;
      endcase
    endfunction

    function logic [7:0] at(int off);
      logic [6:0] a;
      a = head + off[6:0];
      return ring[a];
    endfunction

    function void discard(int n);
      if (n > fill) n = fill;
      head = head + n[6:0];
      fill -= n;
    endfunction

    function void start_wait(logic [31:0] now);
      if (!wait_on) begin
        wait_t0 = now;
        wait_on = 1;
      end
    endfunction

    function void add_single(logic [2:0] st);
      parse_result_t r;
      r.status = st; r.msg_id = 0; r.seq_num = 0; r.pay_len = 0;
      r.pay_byte = 0; r.last = 1;
      pending.push_back(r);
    endfunction

    function logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
      c = c ^ {b, 8'h00};
      for (int i = 0; i < 8; i++)
        c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      return c;
    endfunction

    // Accepted input transaction: update the parser state, queue its results.
    function void note_item(logic mode, logic [7:0] data, logic [31:0] now);
      logic [2:0]  err;
      int          plen, flen, n;
      logic [15:0] crc, rx;
      logic [6:0]  a;
      parse_result_t r;
      err = ST_NONE;
      if (mode == 1'b0) begin
        if (fill >= RING_SIZE) discard(1);
        a = head + fill[6:0];
        ring[a] = data;
        fill++;
      end
      if (wait_on && (now - wait_t0) >= {16'h0, timeout_ms}) begin
        discard(1);
        wait_on = 0;
      end
      forever begin
        // hunt for the two start bytes
        while (fill > 0) begin
          if (at(0) != sof_a) begin
            discard(1); wait_on = 0;
            continue;
          end
          if (fill == 1) begin
            start_wait(now); add_single(err);
            return;
          end
          if (at(1) == sof_b) break;
          discard(1); wait_on = 0;
        end
        if (fill == 0) begin
          wait_on = 0; add_single(err);
          return;
        end
        if (fill < 6) begin
          start_wait(now); add_single(err);
          return;
        end
        if (at(2) != ver_req) begin
          discard(1); wait_on = 0; err = ST_VERSION;
          continue;
        end
        plen = at(5);
        if (plen > MAX_LEN) begin
          discard(1); wait_on = 0; err = ST_LENGTH;
          continue;
        end
        flen = plen + 8;
        if (fill < flen) begin
          start_wait(now); add_single(err);
          return;
        end
        crc = CRC_INIT;
        for (int off = 2; off < 6 + plen; off++) crc = crc_next(crc, at(off));
        rx = {at(6 + plen + 1), at(6 + plen)};
        if (rx != crc) begin
          discard(1); wait_on = 0; err = ST_CRC;
          continue;
        end
        n = (plen == 0) ? 1 : plen;
        for (int k = 0; k < n; k++) begin
          r.status = ST_FRAME; r.msg_id = at(3); r.seq_num = at(4);
          r.pay_len = plen[5:0];
          r.pay_byte = (plen == 0) ? 8'h00 : at(6 + k);
          r.last = (k + 1 == n);
          pending.push_back(r);
        end
        discard(flen);
        wait_on = 0;
        return;
      end
    endfunction

    function void check_result(parse_result_t got);
      parse_result_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status=%0d id=%0h", $time, got.status, got.msg_id);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status || got.msg_id !== exp.msg_id ||
          got.seq_num !== exp.seq_num || got.pay_len !== exp.pay_len ||
          got.pay_byte !== exp.pay_byte || got.last !== exp.last) begin
        $display("%0t: mismatch exp st=%0d id=%h seq=%h len=%0d pb=%h last=%b",
                 $time, exp.status, exp.msg_id, exp.seq_num, exp.pay_len,
                 exp.pay_byte, exp.last);
        $display("%0t:          got st=%0d id=%h seq=%h len=%0d pb=%h last=%b",
                 $time, got.status, got.msg_id, got.seq_num, got.pay_len,
                 got.pay_byte, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_write_en = 0;
  logic [1:0]  cfg_index = 0;
  logic [15:0] cfg_data = 0;

  cfpp_in_if  pkt_in ();
  cfpp_out_if pkt_out ();

  crc_framed_packet_parser_top dut (
    .clk(clk), .rst(rst), .pkt_in(pkt_in), .pkt_out(pkt_out),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  frame_scoreboard sb = new();
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic [31:0] clock_ms = 32'hFFFF_FF00;   // starts near wrap
  int          idle_cycles = 0;
  int          items_sent = 0;
  logic [7:0]  cur_sof_a = 8'hAA, cur_sof_b = 8'h55, cur_ver = 8'h01;

  initial begin
    pkt_in.valid = 0; pkt_in.mode = 0; pkt_in.data_byte = 0; pkt_in.now_ms = 0;
    pkt_out.ready = 0;
  end

  always @(negedge clk)
    pkt_out.ready = rst ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    parse_result_t got;
    if (!rst && pkt_out.valid && pkt_out.ready) begin
      got.status = pkt_out.status; got.msg_id = pkt_out.frame_id;
      got.seq_num = pkt_out.sequence_number; got.pay_len = pkt_out.frame_len;
      got.pay_byte = pkt_out.payload_byte; got.last = pkt_out.last;
      sb.check_result(got);
    end
  end

  // watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((pkt_in.valid && pkt_in.ready) || (pkt_out.valid && pkt_out.ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_item(logic mode, logic [7:0] data);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      pkt_in.valid = 0;
      @(negedge clk);
    end
    pkt_in.valid = 1; pkt_in.mode = mode; pkt_in.data_byte = data;
    pkt_in.now_ms = clock_ms;
    do @(posedge clk); while (!pkt_in.ready);
    sb.note_item(mode, data, clock_ms);
    items_sent++;
    clock_ms = clock_ms + $urandom_range(0, 3);
  endtask

  task automatic poll(logic [31:0] advance);
    clock_ms = clock_ms + advance;
    send_item(1'b1, 8'($urandom_range(255)));
  endtask

  // kind: 0 good, 1 bad version, 2 bad length, 3 bad crc, 4 truncated
  task automatic send_frame(int kind, int plen);
    logic [7:0]  bytes[$];
    logic [15:0] crc;
    logic [7:0]  ver;
    int          npay;
    ver = (kind == 1) ? cur_ver ^ 8'h01 << $urandom_range(7) : cur_ver;
    if (kind == 2) plen = $urandom_range(MAX_LEN + 1, 63);
    // a bad length is caught on the header alone
    npay = (kind == 2) ? 0 : plen;
    bytes = {cur_sof_a, cur_sof_b, ver, 8'($urandom), 8'($urandom), 8'(plen)};
    for (int i = 0; i < npay; i++) bytes.push_back(8'($urandom_range(255)));
    crc = CRC_INIT;
    for (int i = 2; i < bytes.size(); i++) crc = sb.crc_next(crc, bytes[i]);
    if (kind == 3) crc = crc ^ (16'h1 << $urandom_range(15));
    bytes.push_back(crc[7:0]);
    bytes.push_back(crc[15:8]);
    if (kind == 4) bytes = bytes[0:$urandom_range(bytes.size() - 2)];
    foreach (bytes[i]) send_item(1'b0, bytes[i]);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_write_en = 1; cfg_index = idx; cfg_data = val;
    @(negedge clk);
    cfg_write_en = 0;
    sb.write_reg(idx, val);
    case (idx)
      REG_SOF1:    cur_sof_a = val[7:0];
      REG_SOF2:    cur_sof_b = val[7:0];
      REG_VERSION: cur_ver = val[7:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    @(negedge clk);
    pkt_in.valid = 0;
    wait (sb.pending.size() == 0);
    repeat (30) @(posedge clk);
  endtask

  task automatic random_items(int count);
    int stop;
    int pick;
    stop = items_sent + count;
    while (items_sent < stop) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_frame(0, ($urandom_range(9) == 0) ? $urandom_range(MAX_LEN) : $urandom_range(6));
      end else if (pick < 70) begin
        send_frame($urandom_range(1, 4), $urandom_range(5));
      end else if (pick < 85) begin
        send_item(1'b0, 8'($urandom_range(255)));
      end else if (pick < 95) begin
        poll($urandom_range(0, 200));
      end else begin
        clock_ms = $urandom;
        poll(0);
      end
    end
  endtask

  initial begin
    sb.reset_state();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed part
    poll(0);                                 // empty buffer
    send_frame(0, 0);                        // empty payload
    send_frame(0, MAX_LEN);                  // longest payload
    send_frame(1, 1);
    send_frame(2, 0);
    send_frame(3, 2);
    send_frame(4, 3);                        // partial candidate waits
    poll(32'd50);
    poll(32'd100);                           // wait expires, one byte dropped
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h00);
    drain();

    set_reg(REG_TIMEOUT, 16'd0);             // active wait expires on next step
    set_reg(REG_SOF1, 16'h00);
    set_reg(REG_SOF2, 16'hFF);
    set_reg(REG_VERSION, 16'hFF);
    send_frame(4, 2);
    poll(0);
    send_frame(0, 1);
    drain();

    send_idle_pct = 19; recv_idle_pct = 75;
    set_reg(REG_TIMEOUT, 16'hFFFF);
    set_reg(REG_SOF1, 16'hFF);
    set_reg(REG_SOF2, 16'h00);
    set_reg(REG_VERSION, 16'h00);
    random_items(35);
    drain();

    send_idle_pct = 75; recv_idle_pct = 19;
    set_reg(REG_TIMEOUT, 16'd20);
    set_reg(REG_SOF1, 16'h7E);
    set_reg(REG_SOF2, 16'h81);
    set_reg(REG_VERSION, 16'h5A);
    random_items(35);
    drain();

    send_idle_pct = 0; recv_idle_pct = 0;
    set_reg(REG_TIMEOUT, 16'd100);
    set_reg(REG_SOF1, 16'hAA);
    set_reg(REG_SOF2, 16'h55);
    set_reg(REG_VERSION, 16'h01);
    random_items(35);
    drain();

    if (sb.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

>>> crc_framed_packet_parser_top.f
+incdir+rtl/core
rtl/core/cfpp_pkg.sv
rtl/core/cfpp_channels.sv
rtl/core/cfpp_crc.sv
rtl/core/crc_framed_packet_parser_top.sv
rtl/core/cfpp_checker.sv
test/tb_top.sv
